[src/hsc_pkg.sv]
package hsc_pkg;

   localparam int unsigned CHAR_W = 8;
   localparam int unsigned CNT_W = 9;
   localparam int unsigned CSR_DATA_W = 8;

   localparam logic [CNT_W-1:0] CNT_MAX = 9'd511;

   localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [CHAR_W-1:0] CHAR_HYPHEN = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_DOT = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_LO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_HI = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_LO = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_HI = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_LO = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_HI = 8'h7A;

   localparam logic [CSR_DATA_W-1:0] MAX_LABEL_LEN_RESET = 8'd63;
   localparam logic [CSR_DATA_W-1:0] MAX_TOTAL_LEN_RESET = 8'd253;

   typedef enum logic [0:0] {
      CSR_MAX_LABEL_LEN = 1'b0,
      CSR_MAX_TOTAL_LEN = 1'b1
   } csr_index_type;

   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [CNT_W-1:0] count_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

endpackage

[src/hsc_req_if.sv]
interface hsc_req_if;
   import hsc_pkg::*;

   logic valid;
   logic ready;
   char_type char_byte;
   logic end_of_name;

   modport source (output valid, output char_byte, output end_of_name, input ready);
   modport sink (input valid, input char_byte, input end_of_name, output ready);

endinterface

[src/hsc_rsp_if.sv]
interface hsc_rsp_if;

   logic valid;
   logic ready;
   logic name_ok;

   modport source (output valid, output name_ok, input ready);
   modport sink (input valid, input name_ok, output ready);

endinterface

[src/hostname_syntax_checker_top.sv]
// Channel    Direction  Carries
// req_bus    in         char_byte, end_of_name
// rsp_bus    out        name_ok (one per name, after the final byte)
// csr_*      in         max_label_len (index 0), max_total_len (index 1)
//
// One request per cycle unless a final byte stalls; bytes are checked once registered.
// The verdict enters the response register as the final byte leaves the input register.
// A stalled response holds only a final byte in the input register; other bytes go on.
// Reset is synchronous and clears the name state and restores the limit registers.
module hostname_syntax_checker_top (
   input logic clock,
   input logic reset,
   hsc_req_if.sink req_bus,
   hsc_rsp_if.source rsp_bus,
   input logic csr_wr_en,
   input hsc_pkg::csr_index_type csr_index,
   input hsc_pkg::csr_data_type csr_wdata
);
   import hsc_pkg::*;

   csr_data_type max_label_ff, max_label_in;
   csr_data_type max_total_ff, max_total_in;

   logic s1_valid_ff, s1_valid_in;
   char_type s1_char_ff, s1_char_in;
   logic s1_last_ff, s1_last_in;

   count_type byte_cnt_ff, byte_cnt_in;
   count_type label_cnt_ff, label_cnt_in;
   logic hyphen_ff, hyphen_in;
   logic all_digits_ff, all_digits_in;
   logic err_seen_ff, err_seen_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_ok_ff, rsp_ok_in;

   logic out_free;
   logic s1_fire;

   logic is_digit, is_alnum_us, is_hyphen, is_dot, is_first;
   logic byte_err;
   count_type label_new, byte_new;
   logic hyphen_new, all_digits_new, err_new;

   function automatic count_type sat_inc(input count_type v);
      sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign s1_fire = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_bus.ready = !s1_valid_ff || s1_fire;

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.name_ok = rsp_ok_ff;

   always_comb begin
      is_digit = (s1_char_ff >= CHAR_DIGIT_LO) && (s1_char_ff <= CHAR_DIGIT_HI);
      is_alnum_us = is_digit
         || ((s1_char_ff >= CHAR_UPPER_LO) && (s1_char_ff <= CHAR_UPPER_HI))
         || ((s1_char_ff >= CHAR_LOWER_LO) && (s1_char_ff <= CHAR_LOWER_HI))
         || (s1_char_ff == CHAR_UNDERSCORE);
      is_hyphen = (s1_char_ff == CHAR_HYPHEN);
      is_dot = (s1_char_ff == CHAR_DOT);
      is_first = (byte_cnt_ff == '0);

      byte_err = s1_char_ff[CHAR_W-1] || (s1_char_ff == CHAR_NUL);
      label_new = label_cnt_ff;
      hyphen_new = hyphen_ff;
      all_digits_new = all_digits_ff;

      if (is_alnum_us) begin
         label_new = sat_inc(label_cnt_ff);
         hyphen_new = 1'b0;
         all_digits_new = all_digits_ff && is_digit;
      end else if (is_first) begin
         byte_err = 1'b1;
      end else if (is_hyphen) begin
         byte_err = byte_err || (label_cnt_ff == '0);
         label_new = sat_inc(label_cnt_ff);
         hyphen_new = 1'b1;
         all_digits_new = 1'b0;
      end else if (is_dot) begin
         byte_err = byte_err || (label_cnt_ff == '0) || hyphen_ff;
         label_new = '0;
         hyphen_new = 1'b0;
      end else begin
         byte_err = 1'b1;
      end

      byte_new = sat_inc(byte_cnt_ff);
      byte_err = byte_err
         || (label_new > {1'b0, max_label_ff})
         || (byte_new > {1'b0, max_total_ff});
      err_new = err_seen_ff || byte_err;

      if (err_seen_ff) begin
         label_new = label_cnt_ff;
         byte_new = byte_cnt_ff;
         hyphen_new = hyphen_ff;
         all_digits_new = all_digits_ff;
      end
   end

   always_comb begin
      max_label_in = max_label_ff;
      max_total_in = max_total_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_LABEL_LEN: max_label_in = csr_wdata;
            CSR_MAX_TOTAL_LEN: max_total_in = csr_wdata;
            default: ;
         endcase
      end

      s1_valid_in = s1_valid_ff;
      s1_char_in = s1_char_ff;
      s1_last_in = s1_last_ff;
      if (req_bus.ready) begin
         s1_valid_in = req_bus.valid;
         s1_char_in = req_bus.char_byte;
         s1_last_in = req_bus.end_of_name;
      end

      byte_cnt_in = byte_cnt_ff;
      label_cnt_in = label_cnt_ff;
      hyphen_in = hyphen_ff;
      all_digits_in = all_digits_ff;
      err_seen_in = err_seen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_ok_in = rsp_ok_ff;

      if (s1_fire) begin
         if (s1_last_ff) begin
            byte_cnt_in = '0;
            label_cnt_in = '0;
            hyphen_in = 1'b0;
            all_digits_in = 1'b1;
            err_seen_in = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_ok_in = !err_new && (label_new != '0) && !hyphen_new && !all_digits_new;
         end else begin
            byte_cnt_in = byte_new;
            label_cnt_in = label_new;
            hyphen_in = hyphen_new;
            all_digits_in = all_digits_new;
            err_seen_in = err_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_char_ff <= s1_char_in;
      s1_last_ff <= s1_last_in;
      rsp_ok_ff <= rsp_ok_in;
      if (reset) begin
         max_label_ff <= MAX_LABEL_LEN_RESET;
         max_total_ff <= MAX_TOTAL_LEN_RESET;
         s1_valid_ff <= 1'b0;
         byte_cnt_ff <= '0;
         label_cnt_ff <= '0;
         hyphen_ff <= 1'b0;
         all_digits_ff <= 1'b1;
         err_seen_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_label_ff <= max_label_in;
         max_total_ff <= max_total_in;
         s1_valid_ff <= s1_valid_in;
         byte_cnt_ff <= byte_cnt_in;
         label_cnt_ff <= label_cnt_in;
         hyphen_ff <= hyphen_in;
         all_digits_ff <= all_digits_in;
         err_seen_ff <= err_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   // A byte that is not the final one never waits for the response side.
   a_inner_byte_moves: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_last_ff) |-> s1_fire)
      else $error("Non-final byte held in the input register.");

   // After a final byte the name state is back at its starting values.
   a_name_cleared: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_last_ff) |=> (byte_cnt_ff == '0) && (label_cnt_ff == '0)
         && !err_seen_ff && all_digits_ff && !hyphen_ff)
      else $error("Name state not cleared after the final byte.");

   // A new response only follows a final byte leaving the input register.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_fire && s1_last_ff))
      else $error("Response raised without a final byte.");
`endif

endmodule
